/* rtl/bcomp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package bcomp_pkg;

    // configuration register indexes
    localparam int CFG_INDEX_W = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_AC1_AC2 = 3'd0,
        CFG_AC3_AC4 = 3'd1,
        CFG_AC5_AC6 = 3'd2,
        CFG_B1_B2   = 3'd3,
        CFG_MC_MD   = 3'd4
    } cfg_index_t;

    // result status codes
    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_TDIV_ZERO = 2'd1,
        STATUS_P_RANGE   = 2'd2
    } status_t;

    // compensation constants
    localparam int T_OFFSET   = 4000;
    localparam int MC_SHIFT   = 11;
    localparam int B4F_BIAS   = 32768;
    localparam int B7_SCALE   = 50000;
    localparam int P_C1       = 3038;
    localparam int P_C2       = 7357;
    localparam int P_C3       = 3791;

    // divider widths
    localparam int TDIV_NUM_W = 27;
    localparam int TDIV_DEN_W = 20;
    localparam int PDIV_NUM_W = 50;
    localparam int PDIV_DEN_W = 31;

    // fixed register stages outside the two dividers
    localparam int FIXED_STAGES = 15;

    // pressure scale for one oversampling setting
    function automatic logic [15:0] b7_scale(input logic [1:0] oss);
        return 16'(B7_SCALE >> oss);
    endfunction

endpackage

`default_nettype wire

/* rtl/bcomp_udiv.sv */
`timescale 1ns / 1ps
`default_nettype none

// pipelined restoring unsigned divider, one quotient bit per stage
module bcomp_udiv #(
    parameter int NUM_W  = 27,
    parameter int DEN_W  = 20,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  in_num,
    input  logic [DEN_W-1:0]  in_den,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [NUM_W-1:0]  out_quo,
    output logic [SIDE_W-1:0] out_side
);

    logic [DEN_W-1:0]  rem_reg  [NUM_W];
    logic [NUM_W-1:0]  nq_reg   [NUM_W];
    logic [DEN_W-1:0]  den_reg  [NUM_W];
    logic [SIDE_W-1:0] side_reg [NUM_W];
    logic              valid_reg [NUM_W];

    genvar gi;
    for (gi = 0; gi < NUM_W; gi++)
    begin : g_stage
        logic [DEN_W-1:0]  rem_in;
        logic [NUM_W-1:0]  nq_in;
        logic [DEN_W-1:0]  den_in;
        logic [SIDE_W-1:0] side_in;
        logic              valid_in;
        logic [DEN_W:0]    shifted;
        logic [DEN_W:0]    trial;
        logic              qbit;
        logic [DEN_W-1:0]  rem_next;
        logic [NUM_W-1:0]  nq_next;

        if (gi == 0)
        begin : g_first
            assign rem_in   = '0;
            assign nq_in    = in_num;
            assign den_in   = in_den;
            assign side_in  = in_side;
            assign valid_in = in_valid;
        end
        else
        begin : g_rest
            assign rem_in   = rem_reg[gi-1];
            assign nq_in    = nq_reg[gi-1];
            assign den_in   = den_reg[gi-1];
            assign side_in  = side_reg[gi-1];
            assign valid_in = valid_reg[gi-1];
        end

        // shift in next dividend bit, try subtracting
        assign shifted  = {rem_in, nq_in[NUM_W-1]};
        assign trial    = shifted - {1'b0, den_in};
        assign qbit     = ~trial[DEN_W];
        assign rem_next = qbit ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
        assign nq_next  = {nq_in[NUM_W-2:0], qbit};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[gi] <= 1'b0;
            end
            else
            begin
                valid_reg[gi] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[gi]  <= rem_next;
            nq_reg[gi]   <= nq_next;
            den_reg[gi]  <= den_in;
            side_reg[gi] <= side_in;
        end
    end

    assign out_valid = valid_reg[NUM_W-1];
    assign out_quo   = nq_reg[NUM_W-1];
    assign out_side  = side_reg[NUM_W-1];

endmodule

`default_nettype wire

/* rtl/barometer_raw_compensation_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// channel   | signals                                              | dir
// ----------+------------------------------------------------------+-----
// command   | start, busy, raw_temperature, raw_pressure,          | in
//           | oversampling                                         |
// result    | done, temperature_tenths_c, pressure_comp, status    | out
// config    | cfg_valid, cfg_ready, cfg_index, cfg_data            | in
//
// one word accepted every cycle; busy stays low and cfg_ready stays high
// the pipeline is 15 fixed stages plus the 27-stage temperature
// divider and the 50-stage pressure divider, one quotient bit per stage
// done pulses for one cycle per word; the receiver cannot stall
// reset clears all coefficients and every pipeline valid bit
module barometer_raw_compensation_top
    import bcomp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [15:0]            raw_temperature,
    input  logic [18:0]            raw_pressure,
    input  logic [1:0]             oversampling,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]            cfg_data,
    output logic                   done,
    output logic signed [15:0]     temperature_tenths_c,
    output logic [31:0]            pressure_comp,
    output logic [1:0]             status
);

    localparam int LATENCY = FIXED_STAGES + TDIV_NUM_W + PDIV_NUM_W;

    typedef struct packed {
        logic signed [18:0] x1;
        logic [18:0]        up;
        logic [1:0]         oss;
        logic               qneg;
        logic               dz;
    } tside_t;

    typedef struct packed {
        logic signed [15:0] t;
        logic               dz;
        logic               perr;
        logic               dbl;
    } pside_t;

    // coefficient registers
    logic [31:0] coef_ac1_ac2_reg, coef_ac3_ac4_reg, coef_ac5_ac6_reg;
    logic [31:0] coef_b1_b2_reg, coef_mc_md_reg;

    logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
    logic [15:0]        ac4, ac5, ac6;

    assign ac1 = coef_ac1_ac2_reg[31:16];
    assign ac2 = coef_ac1_ac2_reg[15:0];
    assign ac3 = coef_ac3_ac4_reg[31:16];
    assign ac4 = coef_ac3_ac4_reg[15:0];
    assign ac5 = coef_ac5_ac6_reg[31:16];
    assign ac6 = coef_ac5_ac6_reg[15:0];
    assign b1  = coef_b1_b2_reg[31:16];
    assign b2  = coef_b1_b2_reg[15:0];
    assign mc  = coef_mc_md_reg[31:16];
    assign md  = coef_mc_md_reg[15:0];

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_ac1_ac2_reg <= '0;
            coef_ac3_ac4_reg <= '0;
            coef_ac5_ac6_reg <= '0;
            coef_b1_b2_reg   <= '0;
            coef_mc_md_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_AC1_AC2: coef_ac1_ac2_reg <= cfg_data;
                CFG_AC3_AC4: coef_ac3_ac4_reg <= cfg_data;
                CFG_AC5_AC6: coef_ac5_ac6_reg <= cfg_data;
                CFG_B1_B2:   coef_b1_b2_reg   <= cfg_data;
                CFG_MC_MD:   coef_mc_md_reg   <= cfg_data;
                default:     ;
            endcase
        end
    end

    // pipeline registers
    logic               v0_reg, v1_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    logic               v8_reg, v9_reg, v10_reg, v11_reg, v13_reg, v14_reg, v15_reg;
    logic               done_reg;

    logic [15:0]        s0_ut_reg;
    logic [18:0]        s0_up_reg, s1_up_reg, s3_up_reg, s4_up_reg, s5_up_reg;
    logic [18:0]        s6_up_reg, s7_up_reg, s8_up_reg, s9_up_reg;
    logic [1:0]         s0_oss_reg, s1_oss_reg, s3_oss_reg, s4_oss_reg, s5_oss_reg;
    logic [1:0]         s6_oss_reg, s7_oss_reg, s8_oss_reg, s9_oss_reg, s10_oss_reg;
    logic signed [33:0] s1_x1p_reg;
    logic signed [28:0] s3_b5_reg;
    logic               s3_dz_reg, s4_dz_reg, s5_dz_reg, s6_dz_reg, s7_dz_reg;
    logic               s8_dz_reg, s9_dz_reg, s10_dz_reg, s11_dz_reg;
    logic               s13_dz_reg, s14_dz_reg, s15_dz_reg;
    logic signed [15:0] s4_t_reg, s5_t_reg, s6_t_reg, s7_t_reg, s8_t_reg;
    logic signed [15:0] s9_t_reg, s10_t_reg, s11_t_reg, s13_t_reg, s14_t_reg, s15_t_reg;
    logic signed [29:0] s4_b6_reg;
    logic signed [59:0] s5_sqp_reg;
    logic signed [45:0] s5_ac2b6_reg, s5_ac3b6_reg;
    logic signed [31:0] s6_sq_reg, s6_x2a_reg, s6_x1c_reg, s7_x2a_reg, s7_x1c_reg;
    logic signed [47:0] s7_b2sq_reg, s7_b1sq_reg;
    logic signed [31:0] s8_x3_reg;
    logic signed [29:0] s8_x3c_reg;
    logic signed [31:0] s9_b3_reg;
    logic [29:0]        s9_b4f_reg;
    logic               s9_b4fpos_reg, s10_b4fpos_reg;
    logic [45:0]        s10_b4p_reg;
    logic signed [33:0] s10_diff_reg;
    logic [30:0]        s11_b4_reg;
    logic [48:0]        s11_b7_reg;
    logic               s11_perr_reg, s13_perr_reg, s14_perr_reg, s15_perr_reg;
    logic [31:0]        s13_p_reg, s14_p_reg, s15_p_reg;
    logic [47:0]        s14_pdsq_reg;
    logic [44:0]        s14_m_reg;
    logic signed [31:0] s15_x1_reg, s15_x2_reg;
    logic signed [15:0] temp_reg;
    logic [31:0]        pres_reg;
    status_t            status_reg;

    // stage 1: first temperature product
    logic signed [16:0] tdiff;
    logic signed [33:0] x1p_next;

    assign tdiff    = $signed({1'b0, s0_ut_reg}) - $signed({1'b0, ac6});
    assign x1p_next = tdiff * $signed({1'b0, ac5});

    // temperature divider operands
    logic signed [18:0] x1_t;
    logic signed [19:0] den;
    logic signed [26:0] mcx;
    logic [26:0]        tnum;
    logic [19:0]        tden;
    tside_t             tside_in, tside_out;
    logic               tdiv_valid;
    logic [26:0]        tquo;
    logic [$bits(tside_t)-1:0] tside_vec;

    assign x1_t = s1_x1p_reg[33:15];
    assign den  = 20'(x1_t) + 20'(md);
    assign mcx  = {mc, {MC_SHIFT{1'b0}}};
    assign tnum = mc[15] ? 27'(-mcx) : 27'(mcx);
    assign tden = (den == '0) ? 20'd1 : (den[19] ? 20'(-den) : 20'(den));

    assign tside_in.x1   = x1_t;
    assign tside_in.up   = s1_up_reg;
    assign tside_in.oss  = s1_oss_reg;
    assign tside_in.qneg = mc[15] ^ den[19];
    assign tside_in.dz   = (den == '0);

    bcomp_udiv #(
        .NUM_W  (TDIV_NUM_W),
        .DEN_W  (TDIV_DEN_W),
        .SIDE_W ($bits(tside_t))
    ) u_tdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v1_reg),
        .in_num    (tnum),
        .in_den    (tden),
        .in_side   (tside_in),
        .out_valid (tdiv_valid),
        .out_quo   (tquo),
        .out_side  (tside_vec)
    );

    assign tside_out = tside_vec;

    // stage 3: signed quotient, b5
    logic signed [27:0] x2_t;
    logic signed [28:0] b5_next;

    assign x2_t    = tside_out.qneg ? -$signed({1'b0, tquo}) : $signed({1'b0, tquo});
    assign b5_next = 29'(tside_out.x1) + 29'(x2_t);

    // stage 4: temperature rounding and saturation, b6
    logic signed [29:0] b5r;
    logic signed [25:0] t_wide;
    logic signed [15:0] t_next;
    logic signed [29:0] b6_next;

    assign b5r     = 30'(s3_b5_reg) + 30'sd8;
    assign t_wide  = b5r[29:4];
    assign b6_next = 30'(s3_b5_reg) - 30'(T_OFFSET);

    always_comb
    begin
        if (t_wide > 26'sd32767)
        begin
            t_next = 16'sh7fff;
        end
        else if (t_wide < -26'sd32768)
        begin
            t_next = 16'sh8000;
        end
        else
        begin
            t_next = t_wide[15:0];
        end
    end

    // stage 8 sums
    logic signed [31:0] x3_next, x2c, s8_sum;

    assign x2c     = s7_b1sq_reg[47:16];
    assign x3_next = s7_b2sq_reg[42:11] + s7_x2a_reg;
    assign s8_sum  = s7_x1c_reg + x2c + 32'sd2;

    // stage 9: b3 and b4 factor
    logic signed [33:0] b3a;
    logic signed [37:0] b3s;
    logic signed [30:0] b4f;

    assign b3a = {{16{ac1[15]}}, ac1, 2'b00} + 34'(s8_x3_reg);
    assign b3s = (38'(b3a) <<< s8_oss_reg) + 38'sd2;
    assign b4f = 31'(s8_x3c_reg) + 31'(B4F_BIAS);

    // stage 11: b4, b7, range flags
    logic [30:0] b4_next;
    logic        diff_pos;
    logic [48:0] b7_next;

    assign b4_next  = s10_b4p_reg[45:15];
    assign diff_pos = !s10_diff_reg[33] && (s10_diff_reg != '0);
    assign b7_next  = s10_diff_reg[32:0] * b7_scale(s10_oss_reg);

    // pressure divider operands
    logic        b7_small;
    logic [49:0] pnum;
    logic [30:0] pden;
    pside_t      pside_in, pside_out;
    logic        pdiv_valid;
    logic [49:0] pquo;
    logic [$bits(pside_t)-1:0] pside_vec;

    assign b7_small = (s11_b7_reg[48:31] == '0);
    assign pnum     = b7_small ? {s11_b7_reg, 1'b0} : {1'b0, s11_b7_reg};
    assign pden     = (s11_b4_reg == '0) ? 31'd1 : s11_b4_reg;

    assign pside_in.t    = s11_t_reg;
    assign pside_in.dz   = s11_dz_reg;
    assign pside_in.perr = s11_perr_reg;
    assign pside_in.dbl  = !b7_small;

    bcomp_udiv #(
        .NUM_W  (PDIV_NUM_W),
        .DEN_W  (PDIV_DEN_W),
        .SIDE_W ($bits(pside_t))
    ) u_pdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v11_reg),
        .in_num    (pnum),
        .in_den    (pden),
        .in_side   (pside_in),
        .out_valid (pdiv_valid),
        .out_quo   (pquo),
        .out_side  (pside_vec)
    );

    assign pside_out = pside_vec;

    // stage 15: final correction products
    logic [47:0]        x1p_p;
    logic signed [45:0] nm;

    assign x1p_p = s14_pdsq_reg * 48'(P_C1);
    assign nm    = -$signed({1'b0, s14_m_reg});

    // stage 16: final pressure
    logic signed [31:0] fsum;
    logic signed [33:0] fin;
    logic               fin_pos;

    assign fsum    = s15_x1_reg + s15_x2_reg + 32'(P_C3);
    assign fin     = $signed({2'b00, s15_p_reg}) + 34'($signed(fsum[31:4]));
    assign fin_pos = !fin[33] && (fin != '0);

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg   <= 1'b0;
            v1_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            v5_reg   <= 1'b0;
            v6_reg   <= 1'b0;
            v7_reg   <= 1'b0;
            v8_reg   <= 1'b0;
            v9_reg   <= 1'b0;
            v10_reg  <= 1'b0;
            v11_reg  <= 1'b0;
            v13_reg  <= 1'b0;
            v14_reg  <= 1'b0;
            v15_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v0_reg   <= start && !busy;
            v1_reg   <= v0_reg;
            v3_reg   <= tdiv_valid;
            v4_reg   <= v3_reg;
            v5_reg   <= v4_reg;
            v6_reg   <= v5_reg;
            v7_reg   <= v6_reg;
            v8_reg   <= v7_reg;
            v9_reg   <= v8_reg;
            v10_reg  <= v9_reg;
            v11_reg  <= v10_reg;
            v13_reg  <= pdiv_valid;
            v14_reg  <= v13_reg;
            v15_reg  <= v14_reg;
            done_reg <= v15_reg;
        end
    end

    // payload path
    always_ff @(posedge clk)
    begin
        // input capture
        s0_ut_reg  <= raw_temperature;
        s0_up_reg  <= raw_pressure;
        s0_oss_reg <= oversampling;
        // temperature product
        s1_x1p_reg <= x1p_next;
        s1_up_reg  <= s0_up_reg;
        s1_oss_reg <= s0_oss_reg;
        // b5
        s3_b5_reg  <= b5_next;
        s3_up_reg  <= tside_out.up;
        s3_oss_reg <= tside_out.oss;
        s3_dz_reg  <= tside_out.dz;
        // temperature, b6
        s4_t_reg   <= t_next;
        s4_b6_reg  <= b6_next;
        s4_up_reg  <= s3_up_reg;
        s4_oss_reg <= s3_oss_reg;
        s4_dz_reg  <= s3_dz_reg;
        // b6 products
        s5_sqp_reg   <= s4_b6_reg * s4_b6_reg;
        s5_ac2b6_reg <= ac2 * s4_b6_reg;
        s5_ac3b6_reg <= ac3 * s4_b6_reg;
        s5_t_reg     <= s4_t_reg;
        s5_up_reg    <= s4_up_reg;
        s5_oss_reg   <= s4_oss_reg;
        s5_dz_reg    <= s4_dz_reg;
        // scaled terms
        s6_sq_reg  <= s5_sqp_reg[43:12];
        s6_x2a_reg <= s5_ac2b6_reg[42:11];
        s6_x1c_reg <= s5_ac3b6_reg[44:13];
        s6_t_reg   <= s5_t_reg;
        s6_up_reg  <= s5_up_reg;
        s6_oss_reg <= s5_oss_reg;
        s6_dz_reg  <= s5_dz_reg;
        // square products
        s7_b2sq_reg <= b2 * s6_sq_reg;
        s7_b1sq_reg <= b1 * s6_sq_reg;
        s7_x2a_reg  <= s6_x2a_reg;
        s7_x1c_reg  <= s6_x1c_reg;
        s7_t_reg    <= s6_t_reg;
        s7_up_reg   <= s6_up_reg;
        s7_oss_reg  <= s6_oss_reg;
        s7_dz_reg   <= s6_dz_reg;
        // x3 sums
        s8_x3_reg  <= x3_next;
        s8_x3c_reg <= s8_sum[31:2];
        s8_t_reg   <= s7_t_reg;
        s8_up_reg  <= s7_up_reg;
        s8_oss_reg <= s7_oss_reg;
        s8_dz_reg  <= s7_dz_reg;
        // b3, b4 factor
        s9_b3_reg     <= b3s[33:2];
        s9_b4f_reg    <= b4f[29:0];
        s9_b4fpos_reg <= !b4f[30] && (b4f != '0);
        s9_t_reg      <= s8_t_reg;
        s9_up_reg     <= s8_up_reg;
        s9_oss_reg    <= s8_oss_reg;
        s9_dz_reg     <= s8_dz_reg;
        // b4 product, difference
        s10_b4p_reg    <= ac4 * s9_b4f_reg;
        s10_diff_reg   <= $signed({15'd0, s9_up_reg}) - 34'(s9_b3_reg);
        s10_b4fpos_reg <= s9_b4fpos_reg;
        s10_t_reg      <= s9_t_reg;
        s10_oss_reg    <= s9_oss_reg;
        s10_dz_reg     <= s9_dz_reg;
        // b4, b7
        s11_b4_reg   <= b4_next;
        s11_b7_reg   <= b7_next;
        s11_perr_reg <= !s10_b4fpos_reg || (b4_next == '0) || !diff_pos;
        s11_t_reg    <= s10_t_reg;
        s11_dz_reg   <= s10_dz_reg;
        // pressure quotient
        s13_p_reg    <= pside_out.dbl ? {pquo[30:0], 1'b0} : pquo[31:0];
        s13_t_reg    <= pside_out.t;
        s13_dz_reg   <= pside_out.dz;
        s13_perr_reg <= pside_out.perr;
        // correction products
        s14_pdsq_reg <= s13_p_reg[31:8] * s13_p_reg[31:8];
        s14_m_reg    <= s13_p_reg * 45'(P_C2);
        s14_p_reg    <= s13_p_reg;
        s14_t_reg    <= s13_t_reg;
        s14_dz_reg   <= s13_dz_reg;
        s14_perr_reg <= s13_perr_reg;
        // correction terms
        s15_x1_reg   <= x1p_p[47:16];
        s15_x2_reg   <= 32'($signed(nm[45:16]));
        s15_p_reg    <= s14_p_reg;
        s15_t_reg    <= s14_t_reg;
        s15_dz_reg   <= s14_dz_reg;
        s15_perr_reg <= s14_perr_reg;
        // result word
        if (s15_dz_reg)
        begin
            temp_reg   <= '0;
            pres_reg   <= '0;
            status_reg <= STATUS_TDIV_ZERO;
        end
        else if (s15_perr_reg || !fin_pos)
        begin
            temp_reg   <= s15_t_reg;
            pres_reg   <= '0;
            status_reg <= STATUS_P_RANGE;
        end
        else
        begin
            temp_reg   <= s15_t_reg;
            pres_reg   <= fin[31:0];
            status_reg <= STATUS_OK;
        end
    end

    assign done                 = done_reg;
    assign temperature_tenths_c = temp_reg;
    assign pressure_comp        = pres_reg;
    assign status               = status_reg;

    // every result word traces back to an accepted command word
    a_done_from_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LATENCY))
        else $error("result word without matching command word");

    // a zero temperature divisor clears both result fields
    a_tdiv_zero_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == STATUS_TDIV_ZERO) |-> (pressure_comp == '0 &&
        temperature_tenths_c == '0))
        else $error("divisor error word carries data");

    // pressure is only reported with ok status
    a_pressure_ok_only: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != STATUS_OK) |-> (pressure_comp == '0))
        else $error("pressure reported on error word");

endmodule

`default_nettype wire

/* sim/tb_barometer_raw_compensation_top.sv */
`timescale 1ns / 1ps

module tb_barometer_raw_compensation_top;
    import bcomp_pkg::*;

    localparam int LATENCY     = 92;
    localparam int CYCLE_LIMIT = 300000;

    typedef struct {
        logic signed [15:0] temp;
        logic [31:0]        pres;
        status_t            st;
    } reading_t;

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    logic [15:0]            raw_temperature;
    logic [18:0]            raw_pressure;
    logic [1:0]             oversampling;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [31:0]            cfg_data;
    logic                   done;
    logic signed [15:0]     temperature_tenths_c;
    logic [31:0]            pressure_comp;
    logic [1:0]             status;

    logic [31:0] coef_regs [5];
    reading_t    pending_readings [$];
    int          error_count;
    int          words_sent;
    int          words_checked;
    int          cycle_count;
    bit          no_idle;

    barometer_raw_compensation_top DUT (
        .clk                  (clk),
        .rst_n                (rst_n),
        .start                (start),
        .busy                 (busy),
        .raw_temperature      (raw_temperature),
        .raw_pressure         (raw_pressure),
        .oversampling         (oversampling),
        .cfg_valid            (cfg_valid),
        .cfg_ready            (cfg_ready),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data),
        .done                 (done),
        .temperature_tenths_c (temperature_tenths_c),
        .pressure_comp        (pressure_comp),
        .status               (status)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // wrap to a 32-bit signed register
    function automatic longint wrap_s32(input longint v);
        logic signed [31:0] s;
        s = v[31:0];
        return longint'(s);
    endfunction

    // datasheet integer compensation of one reading pair
    function automatic reading_t compensate(input logic [15:0] ut_w, input logic [18:0] up_w,
                                            input logic [1:0] oss);
        reading_t r;
        longint ut, up, ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
        longint x1, x2, x3, den, b5, t, b6, sq, b3, b4f, b4, diff, b7, p, pd, fin;
        ut  = longint'(ut_w);
        up  = longint'(up_w);
        ac1 = longint'($signed(coef_regs[CFG_AC1_AC2][31:16]));
        ac2 = longint'($signed(coef_regs[CFG_AC1_AC2][15:0]));
        ac3 = longint'($signed(coef_regs[CFG_AC3_AC4][31:16]));
        ac4 = longint'(coef_regs[CFG_AC3_AC4][15:0]);
        ac5 = longint'(coef_regs[CFG_AC5_AC6][31:16]);
        ac6 = longint'(coef_regs[CFG_AC5_AC6][15:0]);
        b1  = longint'($signed(coef_regs[CFG_B1_B2][31:16]));
        b2  = longint'($signed(coef_regs[CFG_B1_B2][15:0]));
        mc  = longint'($signed(coef_regs[CFG_MC_MD][31:16]));
        md  = longint'($signed(coef_regs[CFG_MC_MD][15:0]));
        r.temp = '0;
        r.pres = '0;
        r.st   = STATUS_OK;

        // temperature
        x1  = wrap_s32(((ut - ac6) * ac5) >>> 15);
        den = wrap_s32(x1 + md);
        if (den == 0)
        begin
            r.st = STATUS_TDIV_ZERO;
            return r;
        end
        x2 = wrap_s32((mc <<< MC_SHIFT) / den);
        b5 = wrap_s32(x1 + x2);
        t  = (b5 + 8) >>> 4;
        if (t > 32767)
            t = 32767;
        if (t < -32768)
            t = -32768;
        r.temp = t[15:0];

        // b3 and b4
        b6 = wrap_s32(b5 - T_OFFSET);
        sq = wrap_s32((b6 * b6) >>> 12);
        x1 = wrap_s32((b2 * sq) >>> 11);
        x2 = wrap_s32((ac2 * b6) >>> 11);
        x3 = wrap_s32(x1 + x2);
        b3 = wrap_s32((((ac1 * 4 + x3) <<< oss) + 2) >>> 2);
        x1 = wrap_s32((ac3 * b6) >>> 13);
        x2 = wrap_s32((b1 * sq) >>> 16);
        x3 = wrap_s32(x1 + x2 + 2) >>> 2;
        b4f = x3 + B4F_BIAS;
        if (b4f <= 0)
        begin
            r.st = STATUS_P_RANGE;
            return r;
        end
        b4 = (ac4 * b4f) >>> 15;
        diff = up - b3;
        if (b4 == 0 || diff <= 0)
        begin
            r.st = STATUS_P_RANGE;
            return r;
        end

        // pressure quotient and final correction, quotient kept as unsigned 32 bits
        b7 = diff * longint'(B7_SCALE >> oss);
        if (b7 < 64'sh8000_0000)
            p = ((b7 * 2) / b4) & 64'hFFFF_FFFF;
        else
            p = ((b7 / b4) * 2) & 64'hFFFF_FFFF;
        pd  = p >> 8;
        x1  = wrap_s32((pd * pd * P_C1) >>> 16);
        x2  = wrap_s32((-longint'(P_C2) * p) >>> 16);
        fin = p + (wrap_s32(x1 + x2 + P_C3) >>> 4);
        if (fin <= 0)
        begin
            r.st = STATUS_P_RANGE;
            return r;
        end
        r.pres = fin[31:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        error_count++;
        $display("mismatch on %s: got %0d, expected %0d (word %0d)",
                 what, got, want, words_checked);
    endtask

    // result checker
    always @(posedge clk)
    begin
        reading_t want;
        if (rst_n && done)
        begin
            if (pending_readings.size() == 0)
            begin
                error_count++;
                $display("result word with no reading pending");
            end
            else
            begin
                want = pending_readings.pop_front();
                if (temperature_tenths_c !== want.temp)
                    report_mismatch("temperature", temperature_tenths_c, want.temp);
                if (pressure_comp !== want.pres)
                    report_mismatch("pressure", pressure_comp, want.pres);
                if (status !== want.st)
                    report_mismatch("status", status, want.st);
                words_checked++;
            end
        end
    end

    task automatic write_coef(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx <= CFG_MC_MD)
            coef_regs[idx] = data;
        @(posedge clk);
    endtask

    task automatic write_all(input logic [31:0] c0, input logic [31:0] c1, input logic [31:0] c2,
                             input logic [31:0] c3, input logic [31:0] c4);
        write_coef(CFG_AC1_AC2, c0);
        write_coef(CFG_AC3_AC4, c1);
        write_coef(CFG_AC5_AC6, c2);
        write_coef(CFG_B1_B2, c3);
        write_coef(CFG_MC_MD, c4);
    endtask

    // wait for all readings back, then let the pipeline settle
    task automatic drain();
        while (pending_readings.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);
    endtask

    // send one reading word, then maybe idle
    task automatic send_word(input logic [15:0] ut, input logic [18:0] up, input logic [1:0] oss);
        int gap;
        int roll;
        start           <= 1'b1;
        raw_temperature <= ut;
        raw_pressure    <= up;
        oversampling    <= oss;
        do
            @(posedge clk);
        while (busy);
        pending_readings.push_back(compensate(ut, up, oss));
        words_sent++;
        roll = $urandom_range(0, 99);
        if (no_idle || roll < 55)
            gap = 0;
        else if (roll < 95)
            gap = $urandom_range(1, 4);
        else
            gap = $urandom_range(20, 120);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic stop_sending();
        start <= 1'b0;
        @(posedge clk);
    endtask

    // pressure word near the well-formed range, scaled for the setting
    function automatic logic [18:0] typical_up(input logic [1:0] oss);
        return 19'($urandom_range(15000, 45000) << oss);
    endfunction

    task automatic test_datasheet_values();
        write_all({16'd408, -16'sd72}, {-16'sd14383, 16'd32741}, {16'd32757, 16'd23153},
                  {16'd6190, 16'd4}, {-16'sd8711, 16'd2868});
        send_word(16'd27898, 19'd23843, 2'd0);
        for (int o = 0; o < 4; o++)
        begin
            send_word(16'd27898, 19'(23843 << o), 2'(o));
            send_word(16'd0, 19'h7FFFF, 2'(o));
            send_word(16'hFFFF, 19'd0, 2'(o));
        end
        send_word(16'hFFFF, 19'h7FFFF, 2'd3);
        send_word(16'd0, 19'd0, 2'd0);
        stop_sending();
        drain();
    endtask

    task automatic test_special_cases();
        // zero temperature divisor: x1 forced to zero and md zero
        write_all(32'h0198FFB8, 32'hC7D17FE5, 32'h00005A71, 32'h183E0004, 32'hDDE90000);
        send_word(16'd27898, 19'd23843, 2'd1);
        send_word(16'hFFFF, 19'h7FFFF, 2'd3);
        stop_sending();
        drain();
        // temperature saturation both ways with a divisor of one
        write_coef(CFG_MC_MD, 32'h80000001);
        send_word(16'd1000, 19'd30000, 2'd0);
        stop_sending();
        drain();
        write_coef(CFG_MC_MD, 32'h7FFF0001);
        send_word(16'd1000, 19'd30000, 2'd2);
        stop_sending();
        drain();
        // b4 zero and b4 factor not positive
        write_all({16'd408, -16'sd72}, {-16'sd14383, 16'd0}, {16'd32757, 16'd23153},
                  {16'd6190, 16'd4}, {-16'sd8711, 16'd2868});
        send_word(16'd27898, 19'd23843, 2'd0);
        stop_sending();
        drain();
        write_coef(CFG_B1_B2, 32'h80000004);
        write_coef(CFG_AC3_AC4, 32'h80007FE5);
        send_word(16'd27898, 19'd23843, 2'd0);
        send_word(16'hFFFF, 19'd100000, 2'd3);
        stop_sending();
        drain();
        // ignored register indexes
        for (int i = 5; i < 8; i++)
            write_coef(CFG_INDEX_W'(i), $urandom);
        send_word(16'd0, 19'h7FFFF, 2'd2);
        stop_sending();
        drain();
    endtask

    task automatic test_extreme_coefs();
        logic [31:0] pats [4];
        pats = '{32'h00000000, 32'hFFFFFFFF, 32'h80008000, 32'h7FFF7FFF};
        foreach (pats[k])
        begin
            write_all(pats[k], pats[k], pats[k], pats[k], pats[k]);
            repeat (25)
                send_word(16'($urandom), 19'($urandom), 2'($urandom));
            stop_sending();
            drain();
        end
    endtask

    task automatic test_random_phases(input int phases, input int per_phase);
        logic [1:0] oss;
        for (int ph = 0; ph < phases; ph++)
        begin
            if (ph % 3 == 2)
                write_all($urandom, $urandom, $urandom, $urandom, $urandom);
            else
                write_all({16'($urandom_range(0, 800) + 16'd100), 16'($urandom_range(0, 400) - 200)},
                          {16'($urandom_range(0, 30000) - 30000), 16'($urandom_range(20000, 65535))},
                          {16'($urandom_range(20000, 40000)), 16'($urandom_range(15000, 30000))},
                          {16'($urandom_range(3000, 9000)), 16'($urandom_range(0, 60))},
                          {16'($urandom_range(0, 12000) - 12000), 16'($urandom_range(1500, 4000))});
            no_idle = (ph % 4 == 1);
            for (int n = 0; n < per_phase; n++)
            begin
                oss = 2'($urandom);
                if ($urandom_range(0, 99) < 75)
                    send_word(16'($urandom_range(20000, 36000)), typical_up(oss), oss);
                else
                    send_word(16'($urandom), 19'($urandom), oss);
                // hold off until everything has come back, now and then
                if ($urandom_range(0, 199) == 0)
                begin
                    stop_sending();
                    while (pending_readings.size() > 0)
                        @(posedge clk);
                end
            end
            no_idle = 1'b0;
            stop_sending();
            drain();
        end
    endtask

    initial
    begin
        rst_n           = 1'b0;
        start           = 1'b0;
        raw_temperature = '0;
        raw_pressure    = '0;
        oversampling    = '0;
        cfg_valid       = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        error_count     = 0;
        words_sent      = 0;
        words_checked   = 0;
        cycle_count     = 0;
        no_idle         = 1'b0;
        foreach (coef_regs[i])
            coef_regs[i] = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_datasheet_values();
        test_special_cases();
        test_extreme_coefs();
        test_random_phases(10, 125);

        drain();
        $display("sent %0d reading words and checked %0d results", words_sent, words_checked);
        $display("covered datasheet, extreme and random coefficient sets with all settings");
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* sim.f */
rtl/bcomp_pkg.sv
rtl/bcomp_udiv.sv
rtl/barometer_raw_compensation_top.sv
sim/tb_barometer_raw_compensation_top.sv
